### src/ftdj_pkg.sv
// Package for the frame time dejitter unit.
// Holds fixed constants, register indexes and reset values; no dependencies.
package ftdj_pkg;

  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int SCALE_W     = 16;
  localparam int SCALE_FRAC  = 8;
  localparam int WARM_W      = 6;
  localparam int DIVISOR_W   = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_DISABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 2'd2;

  localparam logic [SCALE_W-1:0] UNITY_SCALE   = 16'd256;
  localparam logic [CFG_W-1:0]   WINDOW_RESET  = 16'd8448;

  localparam logic signed [WARM_W-1:0] WARM_START  = -6'sd2;
  localparam logic signed [WARM_W-1:0] WARM_ACTIVE = 6'sd8;
  localparam logic signed [WARM_W-1:0] WARM_STOP   = 6'sd30;

  localparam logic [DIVISOR_W-1:0] EMA_DIVISOR = 6'd10;
  localparam int FIRST_DELTA = 4267;

endpackage

### src/ftdj_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module ftdj_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/ftdj_divider.sv
// Serial dividers: a signed divider by a variable divisor, one quotient bit
// per cycle, and a divider by ten in eight shift-add steps; both truncate
// toward zero. Uses ftdj_pkg for the divisor width and the constant ten.
module ftdj_divider import ftdj_pkg::*; #(
  parameter int W = 42
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic signed [W-1:0]         dividend,
  input  logic [DIVISOR_W-1:0]        divisor,
  output logic                        done,
  output logic signed [W-1:0]         quotient
);

  localparam int CNT_W = $clog2(W + 1);

  logic                 busy;
  logic [CNT_W-1:0]     count;
  logic [W-1:0]         mag;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dvs;
  logic                 neg;
  logic [DIVISOR_W:0]   trial;
  logic                 fits;

  assign trial    = {rem, mag[W-1]};
  assign fits     = trial >= {1'b0, dvs};
  assign quotient = neg ? -$signed(mag) : $signed(mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && (count == CNT_W'(1));
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(W);
        mag   <= dividend[W-1] ? W'(-dividend) : W'(dividend);
        neg   <= dividend[W-1];
        rem   <= '0;
        dvs   <= divisor;
      end else if (busy) begin
        rem   <= fits ? DIVISOR_W'(trial - {1'b0, dvs}) : trial[DIVISOR_W-1:0];
        mag   <= {mag[W-2:0], fits};
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

module ftdj_div10 import ftdj_pkg::*; #(
  parameter int W = 42
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [W-1:0] dividend,
  output logic                done,
  output logic signed [W-1:0] quotient
);

  localparam logic [2:0] LAST_STEP = 3'd7;

  logic         busy;
  logic [2:0]   step;
  logic [W-1:0] n;
  logic [W-1:0] q;
  logic [W-1:0] tenq;
  logic         neg;
  logic [W-1:0] rem;

  assign rem      = n - tenq;
  assign quotient = neg ? -$signed(q) : $signed(q);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && (step == LAST_STEP);
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        n    <= dividend[W-1] ? W'(-dividend) : W'(dividend);
        neg  <= dividend[W-1];
      end else if (busy) begin
        step <= step + 1'b1;
        case (step)
          3'd0: q <= (n >> 1) + (n >> 2);
          3'd1: q <= q + (q >> 4);
          3'd2: q <= q + (q >> 8);
          3'd3: q <= q + (q >> 16);
          3'd4: q <= q + (q >> 32);
          3'd5: q <= q >> 3;
          3'd6: tenq <= (q << 3) + (q << 1);
          default: begin
            if (rem >= W'(EMA_DIVISOR)) begin
              q <= q + 1'b1;
            end
            busy <= 1'b0;
          end
        endcase
      end
    end
  end

endmodule

### src/ftdj_scaler.sv
// Serial shift-add multiplier for the time scale, Q8.8, with saturation.
// Uses ftdj_pkg for the scale width and fraction bits.
module ftdj_scaler import ftdj_pkg::*; #(
  parameter int MW = 41
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [MW-1:0] value,
  input  logic [SCALE_W-1:0]   scale,
  output logic                 done,
  output logic signed [MW-1:0] result
);

  localparam int AW    = MW + SCALE_W;
  localparam int PW    = AW - SCALE_FRAC;
  localparam int CNT_W = $clog2(SCALE_W + 1);

  logic               busy;
  logic [CNT_W-1:0]   count;
  logic [MW-1:0]      mag;
  logic [SCALE_W-1:0] sc;
  logic [AW-1:0]      acc;
  logic               neg;
  logic [PW-1:0]      prod;
  logic [PW-1:0]      limit;
  logic [MW-1:0]      psat;

  always_comb begin
    prod  = acc[AW-1:SCALE_FRAC];
    limit = PW'(1) << (MW - 1);
    psat  = (prod > limit) ? limit[MW-1:0] : prod[MW-1:0];
    if (neg) begin
      result = -$signed(psat);
    end else if (psat[MW-1]) begin
      result = $signed({1'b0, {(MW-1){1'b1}}});
    end else begin
      result = $signed(psat);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && (count == CNT_W'(1));
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(SCALE_W);
        mag   <= value[MW-1] ? MW'(-value) : MW'(value);
        neg   <= value[MW-1];
        sc    <= scale;
        acc   <= '0;
      end else if (busy) begin
        acc   <= (acc << 1) + (sc[SCALE_W-1] ? AW'(mag) : AW'(0));
        sc    <= sc << 1;
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

### src/frame_time_dejitter_unit.sv
// Frame time dejitter unit: one raw Q.8 ms timestamp in, one filtered time
// and frame delta out per word. Depends on ftdj_pkg, ftdj_ram, ftdj_divider,
// ftdj_div10 and ftdj_scaler.
//
// Input channel: in_valid/in_ready with raw_time. Output channel:
// out_valid/out_ready with filtered_time and frame_delta, held in an output
// register. Configuration: cfg_we, cfg_index, cfg_data; index 0 is
// disable_correction, 1 is time_scale, 2 is clamp_window.
// During warm-up or with correction disabled a taken word goes straight to
// the finishing step, which registers the result. With correction active
// it passes two history reads, the serial divide by the warm-up count (one
// bit at a time), an 8-step divide by ten for the smoothing step, the serial
// time scaling when the time scale is not unity, then the correction step
// and the finishing step. No new word is taken while one is in work; the
// next word is taken in the cycle after the result is registered.
// A stalled receiver holds the result and blocks only the finishing step.
// Reset clears counters, smoothing state and last output; history needs no
// clearing since only written entries are ever read.
module frame_time_dejitter_unit import ftdj_pkg::*; #(
  parameter int HISTORY_DEPTH = 32,
  parameter int TIME_WIDTH    = 40
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]             cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [TIME_WIDTH-1:0]        raw_time,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [TIME_WIDTH-1:0]        filtered_time,
  output logic signed [TIME_WIDTH:0]   frame_delta
);

  localparam int TW = TIME_WIDTH;
  localparam int DW = TW + 1;
  localparam int QW = TW + 2;
  localparam int SW = TW + 3;
  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam logic [SW-1:0] DMAX_S = {{(SW - TW){1'b0}}, {TW{1'b1}}};
  localparam logic [SW-1:0] DMIN_S = {{(SW - TW){1'b1}}, {TW{1'b0}}};
  localparam logic [SW-1:0] TMAX_S = {{(SW - TW){1'b0}}, {TW{1'b1}}};

  typedef enum logic [2:0] {
    S_IDLE, S_RPREV, S_RBACK, S_DIV1, S_DIV2, S_SCALE, S_APPLY, S_FINAL
  } state_t;

  state_t state;

  logic                       disable_correction;
  logic [SCALE_W-1:0]         time_scale;
  logic [CFG_W-1:0]           clamp_window;

  logic [AW-1:0]              write_slot;
  logic signed [WARM_W-1:0]   warmup_count;
  logic signed [DW-1:0]       smoothed_delta;
  logic [TW-1:0]              last_output;
  logic [TW-1:0]              raw;
  logic [TW-1:0]              hist_prev;
  logic signed [DW-1:0]       sm_work;
  logic [TW-1:0]              result;

  logic                       div_start;
  logic signed [QW-1:0]       div_dividend;
  logic [DIVISOR_W-1:0]       div_divisor;
  logic                       div_done;
  logic signed [QW-1:0]       div_quotient;
  logic                       ema_start;
  logic                       ema_done;
  logic signed [QW-1:0]       ema_quotient;
  logic                       scale_start;
  logic                       scale_done;
  logic signed [DW-1:0]       scale_result;

  logic [AW-1:0]              prev_slot;
  logic [AW-1:0]              back_slot;
  logic [AW:0]                back_wide;
  logic [AW-1:0]              raddr;
  logic [TW-1:0]              rdata;
  logic                       ram_we;
  logic                       out_space;
  logic                       in_accept;
  logic                       correct;

  logic signed [QW-1:0]       diff;
  logic signed [DW-1:0]       mean;
  logic signed [DW-1:0]       sd0;
  logic signed [SW-1:0]       ema_sum;
  logic signed [DW-1:0]       ema_sat;
  logic signed [SW-1:0]       sum;
  logic signed [SW-1:0]       lo;
  logic signed [SW-1:0]       hi;
  logic signed [SW-1:0]       last_s;
  logic [TW-1:0]              corrected;
  logic signed [DW-1:0]       delta;

  assign in_ready  = (state == S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign out_space = !out_valid || out_ready;
  assign ram_we    = (state == S_FINAL) && out_space;
  assign correct   = !disable_correction && (warmup_count > WARM_ACTIVE);

  always_comb begin
    prev_slot = (write_slot == '0) ? AW'(HISTORY_DEPTH - 1) : write_slot - 1'b1;
    if ({1'b0, prev_slot} >= (AW + 1)'(warmup_count[WARM_W-2:0])) begin
      back_wide = {1'b0, prev_slot} - (AW + 1)'(warmup_count[WARM_W-2:0]);
    end else begin
      back_wide = {1'b0, prev_slot} + (AW + 1)'(HISTORY_DEPTH)
                  - (AW + 1)'(warmup_count[WARM_W-2:0]);
    end
    back_slot = back_wide[AW-1:0];
    raddr     = (state == S_IDLE) ? prev_slot : back_slot;
  end

  always_comb begin
    diff    = $signed({2'b00, hist_prev}) - $signed({2'b00, rdata});
    mean    = div_quotient[DW-1:0];
    sd0     = (smoothed_delta == '0) ? mean : smoothed_delta;
    ema_sum = $signed({{2{sm_work[DW-1]}}, sm_work})
              + $signed({ema_quotient[QW-1], ema_quotient});
    if (ema_sum > $signed(DMAX_S)) begin
      ema_sat = DMAX_S[DW-1:0];
    end else if (ema_sum < $signed(DMIN_S)) begin
      ema_sat = DMIN_S[DW-1:0];
    end else begin
      ema_sat = ema_sum[DW-1:0];
    end
  end

  always_comb begin
    last_s = $signed({3'b000, last_output});
    lo     = $signed({3'b000, raw}) - $signed(SW'(clamp_window));
    hi     = $signed({3'b000, raw}) + $signed(SW'(clamp_window));
    sum    = last_s + $signed({{2{sm_work[DW-1]}}, sm_work});
    if (time_scale == UNITY_SCALE) begin
      if (lo > sum) begin
        sum = lo;
      end
      if (sum > hi) begin
        sum = hi;
      end
    end
    if (sum < last_s) begin
      sum = last_s;
    end
    if (sum > $signed(TMAX_S)) begin
      sum = $signed(TMAX_S);
    end else if (sum < 0) begin
      sum = '0;
    end
    corrected = sum[TW-1:0];
    delta     = $signed({1'b0, result}) - $signed({1'b0, last_output});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      disable_correction <= 1'b0;
      time_scale         <= UNITY_SCALE;
      clamp_window       <= WINDOW_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DISABLE: disable_correction <= cfg_data[0];
        CFG_SCALE:   time_scale         <= cfg_data;
        CFG_WINDOW:  clamp_window       <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      write_slot     <= '0;
      warmup_count   <= WARM_START;
      smoothed_delta <= '0;
      last_output    <= '0;
      out_valid      <= 1'b0;
      div_start      <= 1'b0;
      ema_start      <= 1'b0;
      scale_start    <= 1'b0;
    end else begin
      div_start   <= (state == S_RBACK);
      ema_start   <= (state == S_DIV1) && div_done;
      scale_start <= (state == S_DIV2) && ema_done && (time_scale != UNITY_SCALE);
      if (out_valid && out_ready && !ram_we) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            raw    <= raw_time;
            result <= raw_time;
            state  <= correct ? S_RPREV : S_FINAL;
          end
        end
        S_RPREV: begin
          hist_prev <= rdata;
          state     <= S_RBACK;
        end
        S_RBACK: begin
          div_dividend <= diff;
          div_divisor  <= DIVISOR_W'(warmup_count);
          state        <= S_DIV1;
        end
        S_DIV1: begin
          if (div_done) begin
            sm_work      <= sd0;
            div_dividend <= $signed({mean[DW-1], mean}) - $signed({sd0[DW-1], sd0});
            state        <= S_DIV2;
          end
        end
        S_DIV2: begin
          if (ema_done) begin
            sm_work        <= ema_sat;
            smoothed_delta <= ema_sat;
            if (time_scale != UNITY_SCALE) begin
              state <= S_SCALE;
            end else begin
              state <= S_APPLY;
            end
          end
        end
        S_SCALE: begin
          if (scale_done) begin
            sm_work        <= scale_result;
            smoothed_delta <= scale_result;
            state          <= S_APPLY;
          end
        end
        S_APPLY: begin
          result <= corrected;
          state  <= S_FINAL;
        end
        S_FINAL: begin
          if (out_space) begin
            write_slot    <= (write_slot == AW'(HISTORY_DEPTH - 1)) ? '0
                             : write_slot + 1'b1;
            if (warmup_count < WARM_STOP) begin
              warmup_count <= warmup_count + 1'b1;
            end
            last_output   <= result;
            out_valid     <= 1'b1;
            filtered_time <= result;
            frame_delta   <= (warmup_count == WARM_START) ? DW'(FIRST_DELTA) : delta;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  ftdj_ram #(
    .WIDTH (TW),
    .DEPTH (HISTORY_DEPTH)
  ) u_history (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_slot),
    .wdata (raw),
    .raddr (raddr),
    .rdata (rdata)
  );

  ftdj_divider #(
    .W (QW)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  ftdj_div10 #(
    .W (QW)
  ) u_ema_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ema_start),
    .dividend (div_dividend),
    .done     (ema_done),
    .quotient (ema_quotient)
  );

  ftdj_scaler #(
    .MW (DW)
  ) u_scaler (
    .clk    (clk),
    .rst    (rst),
    .start  (scale_start),
    .value  (sm_work),
    .scale  (time_scale),
    .done   (scale_done),
    .result (scale_result)
  );

`ifndef SYNTHESIS
  a_warmup_range: assert property (@(posedge clk) disable iff (rst)
    warmup_count <= WARM_STOP)
    else $error("warm-up count past its stop value");

  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV1)
    else $error("divider finished with no step waiting");

  a_ema_done_waited: assert property (@(posedge clk) disable iff (rst)
    ema_done |-> state == S_DIV2)
    else $error("smoothing divide finished with no step waiting");

  a_scale_done_waited: assert property (@(posedge clk) disable iff (rst)
    scale_done |-> state == S_SCALE)
    else $error("scaler finished with no step waiting");

  a_write_then_out: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> out_valid && state == S_IDLE)
    else $error("history write without a result word");
`endif

endmodule

### tb/tb_top.sv
// Self-checking bench for frame_time_dejitter_unit: random bursty stimulus,
// a predicting scoreboard and output checks. Depends on ftdj_pkg and the RTL.
module tb_top;
  import ftdj_pkg::*;

  localparam int TW = 40;
  localparam int DEPTH = 32;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [TW-1:0]      ft;
    logic signed [TW:0] fd;
  } timing_t;

  class dejitter_board;
    localparam longint TMAX = (longint'(1) << TW) - 1;
    localparam longint DMIN = -TMAX - 1;
    longint raw_hist[DEPTH];
    int     slot_ptr;
    int     warm;
    longint smooth;
    longint last_out;
    bit     bypass;
    longint scale;
    longint window;
    timing_t expected_times[$];
    int     errors;

    function new();
      foreach (raw_hist[i]) raw_hist[i] = 0;
      slot_ptr = 0;
      warm     = -2;
      smooth   = 0;
      last_out = 0;
      bypass   = 0;
      scale    = UNITY_SCALE;
      window   = WINDOW_RESET;
      errors   = 0;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function longint scaled(longint d);
      longint mag;
      longint p;
      mag = (d < 0) ? -d : d;
      p = (mag * scale) >>> SCALE_FRAC;
      if (p > TMAX + 1) p = TMAX + 1;
      return (d < 0) ? clip(-p, DMIN, TMAX) : clip(p, DMIN, TMAX);
    endfunction

    function void note_input(logic [TW-1:0] raw_in);
      longint raw, result, dlt, diff, mean, sm, lo, hi;
      int prev, back, slot;
      timing_t exp_word;
      raw = longint'(raw_in);
      result = raw;
      slot = slot_ptr;
      if (!bypass && warm > WARM_ACTIVE) begin
        prev = (slot + DEPTH - 1) % DEPTH;
        back = (prev + DEPTH - (warm % DEPTH)) % DEPTH;
        diff = raw_hist[prev] - raw_hist[back];
        mean = diff / longint'(warm);
        if (smooth == 0) smooth = mean;
        sm = clip(smooth + (mean - smooth) / longint'(EMA_DIVISOR), DMIN, TMAX);
        smooth = sm;
        if (scale != UNITY_SCALE) begin
          sm = scaled(sm);
          smooth = sm;
          result = last_out + sm;
        end else begin
          result = last_out + sm;
          lo = raw - window;
          hi = raw + window;
          if (lo > result) result = lo;
          if (result > hi) result = hi;
        end
        if (result < last_out) result = last_out;
        result = clip(result, 0, TMAX);
      end
      raw_hist[slot] = raw;
      slot_ptr = (slot + 1) % DEPTH;
      dlt = (warm == WARM_START) ? FIRST_DELTA : result - last_out;
      if (warm < WARM_STOP) warm++;
      last_out = result;
      exp_word.ft = result[TW-1:0];
      exp_word.fd = dlt[TW:0];
      expected_times.push_back(exp_word);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check(logic [TW-1:0] ft, logic signed [TW:0] fd);
      timing_t e;
      if (expected_times.size() == 0) begin
        report($sformatf("unexpected word ft=%0h fd=%0d", ft, fd));
      end else begin
        e = expected_times.pop_front();
        if (ft !== e.ft) report($sformatf("filtered_time %0h, want %0h", ft, e.ft));
        if (fd !== e.fd) report($sformatf("frame_delta %0d, want %0d", fd, e.fd));
      end
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic [TW-1:0] raw_time = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [TW-1:0] filtered_time;
  logic signed [TW:0] frame_delta;

  dejitter_board board = new();
  longint now_ms;
  int idle_cycles = 0;
  int rx_phase = 0;

  always #4 clk = ~clk;

  frame_time_dejitter_unit #(.HISTORY_DEPTH(DEPTH), .TIME_WIDTH(TW)) DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
    .raw_time(raw_time), .out_valid(out_valid), .out_ready(out_ready),
    .filtered_time(filtered_time), .frame_delta(frame_delta)
  );

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) board.note_input(raw_time);
      if (out_valid && out_ready) board.check(filtered_time, frame_delta);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    rx_phase <= rx_phase + 1;
    case ((rx_phase >> 9) % 4)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= rx_phase[2];
    endcase
  end

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_DISABLE: board.bypass = val[0];
      CFG_SCALE:   board.scale  = val;
      CFG_WINDOW:  board.window = val;
      default: ;
    endcase
  endtask

  task configure(bit dis, int scl, int win);
    write_reg(CFG_DISABLE, CFG_W'(dis));
    write_reg(CFG_SCALE, CFG_W'(scl));
    write_reg(CFG_WINDOW, CFG_W'(win));
  endtask

  task drive_word(logic [TW-1:0] raw);
    in_valid <= 1'b1;
    raw_time <= raw;
    do @(posedge clk); while (!in_ready);
  endtask

  task drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.expected_times.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  function logic [TW-1:0] any_time();
    return {8'($urandom_range(0, 255)), 32'($urandom())};
  endfunction

  function logic [TW-1:0] next_time();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 84) now_ms += 4267 + $urandom_range(0, 600) - 300;
    else if (pick < 88) now_ms += $urandom_range(0, 40000);
    else if (pick < 91) now_ms -= $urandom_range(0, 9000);
    else if (pick < 97) return any_time();
    else return '1;
    if (now_ms < 0) now_ms = 0;
    if (now_ms > dejitter_board::TMAX) now_ms = $urandom_range(0, 100000);
    return now_ms[TW-1:0];
  endfunction

  task run_phase(int n);
    int burst;
    burst = $urandom_range(1, 24);
    for (int i = 0; i < n; i++) begin
      drive_word(next_time());
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        if ($urandom_range(0, 4) != 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end
      end
    end
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    configure(0, UNITY_SCALE, WINDOW_RESET);
    drive_word('0);
    drive_word('1);
    now_ms = 1000;
    for (int i = 0; i < 14; i++) begin
      now_ms += 4267;
      drive_word(now_ms[TW-1:0]);
    end
    drive_word(now_ms[TW-1:0] + 40'd50000);
    drive_word(now_ms[TW-1:0]);
    drive_word('1);
    drive_word(40'd5);
    now_ms = 5;
    drain();
    run_phase(150);
    configure(1, UNITY_SCALE, WINDOW_RESET);
    run_phase(80);
    configure(0, 512, 0);
    run_phase(120);
    configure(0, 0, 8448);
    run_phase(60);
    configure(0, 65535, 65535);
    run_phase(100);
    configure(0, UNITY_SCALE, 0);
    run_phase(100);
    configure(0, 128, 100);
    run_phase(100);
    configure(0, UNITY_SCALE, 65535);
    run_phase(120);
    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
